### rtl/address_pool_split_allocator_defines.svh
// Assertion macros used by the allocator RTL.
`ifndef ADDRESS_POOL_SPLIT_ALLOCATOR_DEFINES_SVH
`define ADDRESS_POOL_SPLIT_ALLOCATOR_DEFINES_SVH
// Implication checked at every rising clock edge outside reset.
`define APSA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define APSA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/apsa_pkg.sv
// ---------------------------------------------------------------------------
// apsa_pkg
// Types and codes of the address pool split allocator.
// ---------------------------------------------------------------------------
package apsa_pkg;
  localparam logic [2:0] OP_ROOT_INIT = 3'd0;
  localparam logic [2:0] OP_ADD_POOL  = 3'd1;
  localparam logic [2:0] OP_RESERVE   = 3'd2;
  localparam logic [2:0] OP_ACCEPT    = 3'd3;
  localparam logic [2:0] OP_REVOKE    = 3'd4;

  localparam logic [1:0] ST_AVAILABLE = 2'd0;
  localparam logic [1:0] ST_RESERVED  = 2'd1;
  localparam logic [1:0] ST_ASSIGNED  = 2'd2;

  localparam logic [1:0] RES_DONE    = 2'd0;
  localparam logic [1:0] RES_IGNORED = 2'd1;
  localparam logic [1:0] RES_NOPOOL  = 2'd2;
  localparam logic [1:0] RES_FULL    = 2'd3;

  localparam logic CFG_ROOT_START = 1'b0;
  localparam logic CFG_ROOT_SIZE  = 1'b1;

  // Write command that a cell applies when the index on the chain is its own.
  typedef struct packed {
    logic       wr_base;   // write start and size
    logic       wr_state;  // write state
    logic       wr_owner;  // write owner
    logic [1:0] state;
  } cell_cmd_t;
endpackage

### rtl/apsa_if.sv
// ---------------------------------------------------------------------------
// apsa_if
// Valid/ready channel with a generic payload.
// ---------------------------------------------------------------------------
interface apsa_if #(
  parameter int W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/address_pool_split_allocator.sv
// The table is scanned by rotating the cell chain once, one slot per cycle,
//   past a single compare unit.
// Reset: synchronous rst empties every slot, clears the local address and
//   loads the root pool registers with start 1 and size 4096.
// One word at a time; a finished result sits in the output register.
`include "address_pool_split_allocator_defines.svh"
module address_pool_split_allocator #(
  parameter int POOL_ENTRIES = 8,
  parameter int ADDRESS_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  apsa_if.sink        in_ch,    // {operation, pool_start, pool_size, peer_link_address}
  apsa_if.source      out_ch,   // {status, result_start, result_size, local_address}
  apsa_if.sink        cfg       // {index, data[31:0]}
);
  import apsa_pkg::*;

  localparam int IW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int AW = ADDRESS_BITS;
  localparam int CW = $clog2(POOL_ENTRIES + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_APPLY = 4'b0100,
    S_OUT   = 4'b1000
  } fsm_t;

  fsm_t state;

  // Config registers.
  logic [31:0] root_start, root_size;
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      root_start <= 32'd1;
      root_size  <= 32'd4096;
    end else if (cfg.valid) begin
      if (cfg.data[32] == CFG_ROOT_START) root_start <= cfg.data[31:0];
      else root_size <= cfg.data[31:0];
    end
  end

  // Captured word.
  logic [2:0]    op;
  logic [AW-1:0] pstart, psize;
  logic [47:0]   peer;
  logic [AW-1:0] own;

  // Cell chain.
  logic [AW-1:0] c_start [POOL_ENTRIES];
  logic [AW-1:0] c_size  [POOL_ENTRIES];
  logic [1:0]    c_state [POOL_ENTRIES];
  logic [47:0]   c_owner [POOL_ENTRIES];

  logic          shift, clear;
  logic [IW-1:0] wr_idx;
  logic          wr_go;
  cell_cmd_t     cmd;
  logic [AW-1:0] wr_start, wr_size;
  logic [47:0]   wr_owner;
  // Secondary base write in the same apply cycle: slot 0 own address take on
  // add_pool, or the shrink of the split pool on reserve.
  logic          sec_go;
  logic [IW-1:0] sec_idx;
  logic [AW-1:0] sec_start, sec_size;

  genvar g;
  generate
    for (g = 0; g < POOL_ENTRIES; g++) begin : g_cell
      localparam int P = (g + 1) % POOL_ENTRIES;
      logic          we, cl, hit, hit2;
      cell_cmd_t     cc;
      logic [AW-1:0] ws, wz;
      always_comb begin
        hit  = wr_go && (wr_idx == IW'(g));
        hit2 = sec_go && (sec_idx == IW'(g));
        we   = hit || hit2;
        // root init clears every slot except the one that takes the root pool
        cl   = clear && !hit;
        cc   = cmd;
        ws   = wr_start;
        wz   = wr_size;
        if (hit2) begin
          if (!hit) begin
            cc = '{wr_base: 1'b1, wr_state: 1'b0, wr_owner: 1'b0, state: ST_AVAILABLE};
          end
          ws = sec_start;
          wz = sec_size;
        end
      end
      apsa_cell #(.AW(AW)) u_cell (
        .clk, .rst, .clear(cl), .shift,
        .wr_en(we), .cmd(cc), .wr_start(ws), .wr_size(wz), .wr_owner,
        .prev_start(c_start[P]), .prev_size(c_size[P]),
        .prev_state(c_state[P]), .prev_owner(c_owner[P]),
        .start(c_start[g]), .size(c_size[g]), .state(c_state[g]), .owner(c_owner[g])
      );
    end
  endgenerate

  // Scan results; slot 0 of the chain holds the slot numbered by cnt.
  logic [CW-1:0] cnt;
  logic          f_empty, f_res, f_any, f_best;
  logic [IW-1:0] i_empty, i_res, i_any, i_best;
  logic [AW-1:0] best_size, best_start, res_start, res_size;

  logic [AW-1:0] h_start, h_size;
  logic [1:0]    h_state;
  logic          h_nonempty, h_own;
  assign h_start    = c_start[0];
  assign h_size     = c_size[0];
  assign h_state    = c_state[0];
  assign h_nonempty = (h_start != '0);
  assign h_own      = h_nonempty && (c_owner[0] == peer);

  // Result register.
  logic [1:0]    o_status;
  logic [AW-1:0] o_start, o_size;

  logic in_acc;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.data  = {o_status, 32'(o_start), 32'(o_size), 32'(own)};

  // Apply decisions.
  logic [AW-1:0] keep, upper;
  assign keep  = best_size >> 1;
  assign upper = best_start + keep;

  always_comb begin
    clear    = 1'b0;
    shift    = (state == S_SCAN);
    wr_go    = 1'b0;
    wr_idx   = '0;
    cmd      = '0;
    wr_start = '0;
    wr_size  = '0;
    wr_owner = '0;
    sec_go    = 1'b0;
    sec_idx   = '0;
    sec_start = '0;
    sec_size  = '0;
    if (state == S_APPLY) begin
      case (op)
        OP_ROOT_INIT: begin
          if (own == '0) begin
            clear = 1'b1;
            wr_go = 1'b1;
            wr_idx = '0;
            cmd = '{wr_base: 1'b1, wr_state: 1'b1, wr_owner: 1'b1, state: ST_AVAILABLE};
            wr_start = AW'(root_start);
            wr_size = AW'(root_size);
          end
        end
        OP_ADD_POOL: begin
          if (own == '0 && pstart != '0 && psize != '0 && f_empty) begin
            wr_go = 1'b1;
            wr_idx = i_empty;
            cmd = '{wr_base: 1'b1, wr_state: 1'b1, wr_owner: 1'b1, state: ST_AVAILABLE};
            wr_start = pstart;
            wr_size = psize;
            if (i_empty == '0) begin
              sec_go = 1'b1;
              sec_start = pstart + AW'(1);
              sec_size = psize - AW'(1);
            end else if (c_start[0] != '0 && c_size[0] != '0) begin
              sec_go = 1'b1;
              sec_start = c_start[0] + AW'(1);
              sec_size = c_size[0] - AW'(1);
            end
          end
        end
        OP_RESERVE: begin
          if (!f_res && f_best && upper != '0 && f_empty) begin
            wr_go = 1'b1;
            wr_idx = i_empty;
            cmd = '{wr_base: 1'b1, wr_state: 1'b1, wr_owner: 1'b1, state: ST_RESERVED};
            wr_start = upper;
            wr_size = best_size - keep;
            wr_owner = peer;
            // split pool keeps its start and the lower half
            sec_go = 1'b1;
            sec_idx = i_best;
            sec_start = best_start;
            sec_size = keep;
          end
        end
        OP_ACCEPT: begin
          if (f_res) begin
            wr_go = 1'b1;
            wr_idx = i_res;
            cmd = '{wr_base: 1'b0, wr_state: 1'b1, wr_owner: 1'b0, state: ST_ASSIGNED};
          end
        end
        OP_REVOKE: begin
          if (f_any) begin
            wr_go = 1'b1;
            wr_idx = i_any;
            cmd = '{wr_base: 1'b0, wr_state: 1'b1, wr_owner: 1'b1, state: ST_AVAILABLE};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      own   <= '0;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            op     <= in_ch.data[114:112];
            pstart <= AW'(in_ch.data[111:80]);
            psize  <= AW'(in_ch.data[79:48]);
            peer   <= in_ch.data[47:0];
            cnt    <= '0;
            f_empty <= 1'b0; f_res <= 1'b0; f_any <= 1'b0; f_best <= 1'b0;
            i_empty <= '0; i_res <= '0; i_any <= '0; i_best <= '0;
            best_size <= '0; best_start <= '0; res_start <= '0; res_size <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!h_nonempty && !f_empty) begin
            f_empty <= 1'b1; i_empty <= cnt[IW-1:0];
          end
          if (h_own && h_state == ST_RESERVED && !f_res) begin
            f_res <= 1'b1; i_res <= cnt[IW-1:0];
            res_start <= h_start; res_size <= h_size;
          end
          if (h_own && (h_state == ST_RESERVED || h_state == ST_ASSIGNED) && !f_any) begin
            f_any <= 1'b1; i_any <= cnt[IW-1:0];
          end
          if (h_nonempty && h_state == ST_AVAILABLE && h_size >= AW'(2) &&
              (!f_best || h_size > best_size)) begin
            f_best <= 1'b1; i_best <= cnt[IW-1:0];
            best_size <= h_size; best_start <= h_start;
          end
          cnt <= cnt + CW'(1);
          if (cnt == CW'(POOL_ENTRIES - 1)) state <= S_APPLY;
        end
        S_APPLY: begin
          o_start  <= '0;
          o_size   <= '0;
          o_status <= RES_NOPOOL;
          case (op)
            OP_ROOT_INIT: o_status <= (own != '0) ? RES_IGNORED : RES_DONE;
            OP_ADD_POOL: begin
              if (own != '0) o_status <= RES_IGNORED;
              else if (pstart == '0 || psize == '0) o_status <= RES_NOPOOL;
              else if (!f_empty) o_status <= RES_FULL;
              else begin
                o_status <= RES_DONE;
                if (i_empty == '0) own <= pstart;
                else if (c_start[0] != '0 && c_size[0] != '0) own <= c_start[0];
              end
            end
            OP_RESERVE: begin
              if (f_res) begin
                o_status <= RES_DONE; o_start <= res_start; o_size <= res_size;
              end else if (!f_best || upper == '0) o_status <= RES_NOPOOL;
              else if (!f_empty) o_status <= RES_FULL;
              else begin
                o_status <= RES_DONE; o_start <= upper; o_size <= best_size - keep;
              end
            end
            OP_ACCEPT: begin
              if (f_res) begin
                o_status <= RES_DONE; o_start <= res_start; o_size <= res_size;
              end
            end
            OP_REVOKE: if (f_any) o_status <= RES_DONE;
            default: ;
          endcase
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `APSA_ASSERT_NXT(a_in_starts_scan, clk, rst, in_acc, state == S_SCAN)
  `APSA_ASSERT_IMP(a_scan_cnt, clk, rst, state == S_SCAN, cnt < CW'(POOL_ENTRIES))
  `APSA_ASSERT_NXT(a_out_hold, clk, rst, out_ch.valid && !out_ch.ready, out_ch.valid)
endmodule

### rtl/apsa_cell.sv
// ---------------------------------------------------------------------------
// apsa_cell
// One pool slot; in scan mode it passes its contents down the chain.
// ---------------------------------------------------------------------------
module apsa_cell #(
  parameter int AW = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clear,
  input  logic                     shift,      // rotate contents one place
  input  logic                     wr_en,
  input  apsa_pkg::cell_cmd_t      cmd,
  input  logic [AW-1:0]            wr_start,
  input  logic [AW-1:0]            wr_size,
  input  logic [47:0]              wr_owner,
  input  logic [AW-1:0]            prev_start,
  input  logic [AW-1:0]            prev_size,
  input  logic [1:0]               prev_state,
  input  logic [47:0]              prev_owner,
  output logic [AW-1:0]            start,
  output logic [AW-1:0]            size,
  output logic [1:0]               state,
  output logic [47:0]              owner
);
  import apsa_pkg::*;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      start <= '0;
      size  <= '0;
      state <= ST_AVAILABLE;
      owner <= '0;
    end else if (shift) begin
      start <= prev_start;
      size  <= prev_size;
      state <= prev_state;
      owner <= prev_owner;
    end else if (wr_en) begin
      if (cmd.wr_base) begin
        start <= wr_start;
        size  <= wr_size;
      end
      if (cmd.wr_state) state <= cmd.state;
      if (cmd.wr_owner) owner <= wr_owner;
    end
  end
endmodule
